>>> hw/rtl/biu_pkg.sv
// ----------------------------------------------------------------------------
// biu_pkg
// Shared constants, types and the interpolation step of the upscaler.
// ----------------------------------------------------------------------------
package biu_pkg;

  localparam int IMG_SIZE = 16;
  localparam int CNT_W    = (IMG_SIZE > 1) ? $clog2(IMG_SIZE) : 1;
  localparam int PIX_W    = 8;
  localparam int COORD_W  = 6;
  localparam int CALC_W   = (CNT_W + 2 > COORD_W) ? CNT_W + 2 : COORD_W;

  // Zoom register values. Any value other than ZOOM_X3 acts as ZOOM_X2.
  localparam logic [1:0] ZOOM_X2 = 2'd2;
  localparam logic [1:0] ZOOM_X3 = 2'd3;

  // One output pixel handed from the sequencer to the datapath.
  typedef struct packed {
    logic                valid;
    logic [PIX_W-1:0]    p00;
    logic [PIX_W-1:0]    p01;
    logic [PIX_W-1:0]    p10;
    logic [PIX_W-1:0]    p11;
    logic [1:0]          a;
    logic [1:0]          b;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic                last;
    logic                z3;
  } issue_t;

  // p0 + trunc(t*(p1-p0)/z) with z = 3 when z3 is set, else 2. The result
  // always lies between p0 and p1, so it fits the pixel width.
  function automatic logic [PIX_W-1:0] lerp(input logic [PIX_W-1:0] p0,
                                            input logic [PIX_W-1:0] p1,
                                            input logic [1:0]       t,
                                            input logic             z3);
    logic signed [9:0]  d;
    logic signed [10:0] prod;
    logic               neg;
    logic [9:0]         mag;
    logic [18:0]        scaled;
    logic [PIX_W-1:0]   q;
    d = $signed({2'b00, p1}) - $signed({2'b00, p0});
    case (t)
      2'd1:    prod = {d[9], d};
      2'd2:    prod = {d, 1'b0};
      default: prod = '0;
    endcase
    neg = prod[10];
    mag = neg ? 10'(-prod) : prod[9:0];
    // Division by three as a multiply by 683/2048, exact for values to 510.
    scaled = {9'd0, mag} * 19'd683;
    q = z3 ? scaled[18:11] : mag[8:1];
    return neg ? (p0 - q) : (p0 + q);
  endfunction

endpackage

>>> hw/rtl/biu_line_store.sv
// ----------------------------------------------------------------------------
// biu_line_store
// One row of source pixels, single port, read-first, registered read.
// ----------------------------------------------------------------------------
module biu_line_store (
  input  logic                        clk,
  input  logic                        en,
  input  logic [biu_pkg::CNT_W-1:0]   addr,
  input  logic [biu_pkg::PIX_W-1:0]   wdata,
  output logic [biu_pkg::PIX_W-1:0]   rdata
);
  import biu_pkg::*;

  logic [PIX_W-1:0] mem [IMG_SIZE];

  // The old entry is read out in the same cycle the new pixel replaces it.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

>>> hw/rtl/biu_interp.sv
// ----------------------------------------------------------------------------
// biu_interp
// Two-stage interpolation datapath: horizontal pass, then vertical pass into
// the output register.
// ----------------------------------------------------------------------------
module biu_interp (
  input  logic                          clk,
  input  logic                          rst,
  input  biu_pkg::issue_t               issue,
  output logic                          adv,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [biu_pkg::COORD_W-1:0]   out_row,
  output logic [biu_pkg::COORD_W-1:0]   out_col,
  output logic [biu_pkg::PIX_W-1:0]     out_value,
  output logic                          run_last
);
  import biu_pkg::*;

  logic               s1_valid;
  logic [PIX_W-1:0]   s1_h0;
  logic [PIX_W-1:0]   s1_h1;
  logic [1:0]         s1_a;
  logic [COORD_W-1:0] s1_row;
  logic [COORD_W-1:0] s1_col;
  logic               s1_last;
  logic               s1_z3;

  // The whole pipe moves when the output register is free or being taken.
  assign adv = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= issue.valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_h0     <= lerp(issue.p00, issue.p01, issue.b, issue.z3);
      s1_h1     <= lerp(issue.p10, issue.p11, issue.b, issue.z3);
      s1_a      <= issue.a;
      s1_row    <= issue.row;
      s1_col    <= issue.col;
      s1_last   <= issue.last;
      s1_z3     <= issue.z3;
      out_value <= lerp(s1_h0, s1_h1, s1_a, s1_z3);
      out_row   <= s1_row;
      out_col   <= s1_col;
      run_last  <= s1_last;
    end
  end

endmodule

>>> hw/rtl/bilinear_integer_upscaler.sv
// ----------------------------------------------------------------------------
// bilinear_integer_upscaler
// Streaming bilinear 2x/3x upscaler for a square grayscale image.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order on the input channel (in_valid,
// in_stall, pixel_value), one item per pixel. The output channel (out_valid,
// out_stall, out_row, out_col, out_value, run_last) carries every enlarged
// pixel as an item with its coordinates; run_last marks the final item
// caused by one source pixel. An input item that completes no block causes
// no output item. The user must write the zoom register (cfg_we/cfg_wdata)
// only while the block is idle; the block does not enforce this. Any value
// other than 3 acts as 2. One source pixel occupies the block for its line
// store read and then while its output items are issued, zoom^2 items per
// completed block, up to four blocks. After acceptance the line store is
// read in S_READ; each item is issued in S_EMIT and passes the interpolation
// pipe's two register stages to the output. A stalled receiver freezes the
// whole pipe and the issue sequencer; no item is dropped.
// Reset clears the position counters, the left and upper-left pixels and the
// zoom register (to 2); the line store needs no clearing, since only entries
// written in the current image are used.
// ----------------------------------------------------------------------------
module bilinear_integer_upscaler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [biu_pkg::PIX_W-1:0]     pixel_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [biu_pkg::COORD_W-1:0]   out_row,
  output logic [biu_pkg::COORD_W-1:0]   out_col,
  output logic [biu_pkg::PIX_W-1:0]     out_value,
  output logic                          run_last
);
  import biu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(IMG_SIZE - 1);

  state_t           state;
  logic [1:0]       zoom;
  logic [CNT_W-1:0] row_cnt;
  logic [CNT_W-1:0] col_cnt;
  logic [PIX_W-1:0] left_pixel;
  logic [PIX_W-1:0] upper_left_pixel;

  // Snapshot of the item being expanded.
  logic [PIX_W-1:0] item_px;
  logic [PIX_W-1:0] item_left;
  logic [PIX_W-1:0] item_upleft;
  logic [PIX_W-1:0] item_above;
  logic [CNT_W-1:0] item_row;
  logic [CNT_W-1:0] item_col;
  logic             item_z3;
  logic [3:0]       blk_en;

  // Issue position: current block, vertical and horizontal step.
  logic [1:0]       blk;
  logic [1:0]       step_a;
  logic [1:0]       step_b;

  logic             accept;
  logic [PIX_W-1:0] store_rdata;
  logic             adv;
  issue_t           issue;
  logic             last_row;
  logic             last_col;
  logic [1:0]       zmax;
  logic             first_found;
  logic [1:0]       first_blk;
  logic             next_found;
  logic [1:0]       next_blk;
  logic [CNT_W-1:0] bi;
  logic [CNT_W-1:0] bj;
  logic [CALC_W-1:0] row_calc;
  logic [CALC_W-1:0] col_calc;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign last_row = (row_cnt == LAST_IDX);
  assign last_col = (col_cnt == LAST_IDX);
  assign zmax     = item_z3 ? 2'd2 : 2'd1;

  // Lowest enabled block at or above a starting index.
  function automatic logic [2:0] find_blk(input logic [3:0] en, input logic [2:0] from);
    logic [2:0] res;
    res = 3'b000;
    for (int k = 3; k >= 0; k--) begin
      if (en[k] && (3'(k) >= from)) begin
        res = {1'b1, 2'(k)};
      end
    end
    return res;
  endfunction

  assign {first_found, first_blk} = find_blk(blk_en, 3'd0);
  assign {next_found, next_blk}   = find_blk(blk_en, {1'b0, blk} + 3'd1);

  biu_line_store u_line_store (
    .clk   (clk),
    .en    (accept),
    .addr  (col_cnt),
    .wdata (pixel_value),
    .rdata (store_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      zoom             <= ZOOM_X2;
      row_cnt          <= '0;
      col_cnt          <= '0;
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else begin
      if (cfg_we) begin
        zoom <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state      <= S_READ;
            left_pixel <= pixel_value;
            if (last_col) begin
              col_cnt <= '0;
              row_cnt <= last_row ? '0 : row_cnt + 1'b1;
            end else begin
              col_cnt <= col_cnt + 1'b1;
            end
          end
        end
        S_READ: begin
          upper_left_pixel <= store_rdata;
          state            <= first_found ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (adv && step_a == zmax && step_b == zmax && !next_found) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item snapshot and issue counters.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_px     <= pixel_value;
      item_left   <= left_pixel;
      item_upleft <= upper_left_pixel;
      item_row    <= row_cnt;
      item_col    <= col_cnt;
      item_z3     <= (zoom == ZOOM_X3);
      blk_en      <= {last_row && last_col,
                      last_row && (col_cnt != '0),
                      (row_cnt != '0) && last_col,
                      (row_cnt != '0) && (col_cnt != '0)};
    end
    if (state == S_READ) begin
      item_above <= store_rdata;
      blk        <= first_blk;
      step_a     <= 2'd0;
      step_b     <= 2'd0;
    end else if (state == S_EMIT && adv) begin
      if (step_b == zmax) begin
        step_b <= 2'd0;
        if (step_a == zmax) begin
          step_a <= 2'd0;
          blk    <= next_blk;
        end else begin
          step_a <= step_a + 2'd1;
        end
      end else begin
        step_b <= step_b + 2'd1;
      end
    end
  end

  // Block corner of the current block: blk[1] picks the lower block row,
  // blk[0] the right block column.
  assign bi = blk[1] ? item_row : item_row - 1'b1;
  assign bj = blk[0] ? item_col : item_col - 1'b1;
  assign row_calc = CALC_W'({bi, 1'b0}) + (item_z3 ? CALC_W'(bi) : '0) + CALC_W'(step_a);
  assign col_calc = CALC_W'({bj, 1'b0}) + (item_z3 ? CALC_W'(bj) : '0) + CALC_W'(step_b);

  always_comb begin
    issue.valid = (state == S_EMIT);
    issue.a     = step_a;
    issue.b     = step_b;
    issue.row   = row_calc[COORD_W-1:0];
    issue.col   = col_calc[COORD_W-1:0];
    issue.last  = (step_a == zmax) && (step_b == zmax) && !next_found;
    issue.z3    = item_z3;
    // Neighbors past the right or bottom border are zero.
    case (blk)
      2'd0: begin
        issue.p00 = item_upleft;
        issue.p01 = item_above;
        issue.p10 = item_left;
        issue.p11 = item_px;
      end
      2'd1: begin
        issue.p00 = item_above;
        issue.p01 = '0;
        issue.p10 = item_px;
        issue.p11 = '0;
      end
      2'd2: begin
        issue.p00 = item_left;
        issue.p01 = item_px;
        issue.p10 = '0;
        issue.p11 = '0;
      end
      default: begin
        issue.p00 = item_px;
        issue.p01 = '0;
        issue.p10 = '0;
        issue.p11 = '0;
      end
    endcase
  end

  biu_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .run_last  (run_last)
  );

endmodule

>>> tb/sv/upscale_checker.sv
// ----------------------------------------------------------------------------
// upscale_checker
// Watches the upscaler's channels, predicts every output pixel and compares.
// ----------------------------------------------------------------------------
module upscale_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [biu_pkg::PIX_W-1:0]     pixel_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [biu_pkg::COORD_W-1:0]   out_row,
  input  logic [biu_pkg::COORD_W-1:0]   out_col,
  input  logic [biu_pkg::PIX_W-1:0]     out_value,
  input  logic                          run_last,
  input  logic                          run_done,
  output int                            pend_count,
  output int                            fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import biu_pkg::*;

  localparam int         MAX_SHOWN = 10;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   value;
    logic               last;
  } upix_t;

  upix_t            pending_pixels[$];
  upix_t            step_pixels[$];
  logic [PIX_W-1:0] line_mem [IMG_SIZE];
  logic [PIX_W-1:0] left_px;
  logic [PIX_W-1:0] upleft_px;
  logic [CNT_W-1:0] row_cnt;
  logic [CNT_W-1:0] col_cnt;
  logic [1:0]       zoom_reg;
  int               errs = 0;
  bit               done_seen = 1'b0;

  // Integer division in SystemVerilog truncates toward zero.
  function automatic int interp(input int p0, input int p1, input int t, input int z);
    return p0 + (t * (p1 - p0)) / z;
  endfunction

  task automatic push_block(input int bi, input int bj, input int p00, input int p01,
                            input int p10, input int p11, input int z);
    int    h0;
    int    h1;
    upix_t px;
    for (int a = 0; a < z; a++) begin
      for (int b = 0; b < z; b++) begin
        h0       = interp(p00, p01, b, z);
        h1       = interp(p10, p11, b, z);
        px.row   = COORD_W'(bi * z + a);
        px.col   = COORD_W'(bj * z + b);
        px.value = PIX_W'(interp(h0, h1, a, z));
        px.last  = 1'b0;
        step_pixels.push_back(px);
      end
    end
  endtask

  task automatic predict_pixel(input logic [PIX_W-1:0] px_in);
    int    z;
    int    px;
    int    above;
    bit    last_row;
    bit    last_col;
    upix_t tail;
    z        = (zoom_reg == ZOOM_X3) ? 3 : 2;
    px       = int'(px_in);
    above    = int'(line_mem[col_cnt]);
    last_row = (int'(row_cnt) == IMG_SIZE - 1);
    last_col = (int'(col_cnt) == IMG_SIZE - 1);
    step_pixels.delete();
    if (row_cnt != 0 && col_cnt != 0) begin
      push_block(int'(row_cnt) - 1, int'(col_cnt) - 1, int'(upleft_px), above,
                 int'(left_px), px, z);
    end
    if (row_cnt != 0 && last_col) begin
      push_block(int'(row_cnt) - 1, int'(col_cnt), above, 0, px, 0, z);
    end
    if (last_row && col_cnt != 0) begin
      push_block(int'(row_cnt), int'(col_cnt) - 1, int'(left_px), px, 0, 0, z);
    end
    if (last_row && last_col) begin
      push_block(int'(row_cnt), int'(col_cnt), px, 0, 0, 0, z);
    end
    if (step_pixels.size() != 0) begin
      tail      = step_pixels.pop_back();
      tail.last = 1'b1;
      step_pixels.push_back(tail);
    end
    foreach (step_pixels[k]) pending_pixels.push_back(step_pixels[k]);

    upleft_px         = PIX_W'(above);
    line_mem[col_cnt] = px_in;
    left_px           = px_in;
    if (last_col) begin
      col_cnt = '0;
      row_cnt = last_row ? '0 : row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    upix_t want;
    if (rst) begin
      zoom_reg  = ZOOM_X2;
      left_px   = '0;
      upleft_px = '0;
      row_cnt   = '0;
      col_cnt   = '0;
      foreach (line_mem[k]) line_mem[k] = '0;
      pending_pixels.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          errs++;
          if (errs <= MAX_SHOWN) begin
            $display("[%0t] unexpected output pixel row %0d col %0d value %0d last %0b",
                     $realtime, out_row, out_col, out_value, run_last);
          end
        end else begin
          want = pending_pixels.pop_front();
          if (out_row !== want.row || out_col !== want.col ||
              out_value !== want.value || run_last !== want.last) begin
            errs++;
            if (errs <= MAX_SHOWN) begin
              $display("[%0t] mismatch row/col/value/last: want %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                       $realtime, want.row, want.col, want.value, want.last,
                       out_row, out_col, out_value, run_last);
            end
          end
        end
      end
      if (in_valid && !in_stall) predict_pixel(pixel_value);
      if (cfg_we) zoom_reg = cfg_wdata;
      if (run_done && !done_seen) begin
        done_seen = 1'b1;
        if (pending_pixels.size() != 0) begin
          errs += pending_pixels.size();
          $display("[%0t] %0d output pixels never arrived", $realtime,
                   pending_pixels.size());
        end
      end
    end
    pend_count <= pending_pixels.size();
    fail_count <= errs;
  end

endmodule

>>> tb/sv/bilinear_integer_upscaler_tb.sv
// ----------------------------------------------------------------------------
// bilinear_integer_upscaler_tb
// Stimulus and verdict for the streaming bilinear upscaler.
// ----------------------------------------------------------------------------
// A short directed image start with full-swing pixels is followed by random
// pixels that carry on through the first ten rows of a 16x16 image, so the
// interior blocks and the blocks on the right border are reached many times.
// Between phases the zoom register is rewritten with 3, 2 and the two values
// that alias to 2. Each phase picks a traffic mode: no gaps, a mostly idle
// sender, a mostly stalling receiver, or light gaps on both sides. The
// checker beside the block predicts and compares every output pixel; this
// module only drives the block and reports the verdict.
// ----------------------------------------------------------------------------
module bilinear_integer_upscaler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import biu_pkg::*;

  // Zoom register values that behave as a factor of 2.
  localparam logic [1:0] ZOOM_ALIAS0 = 2'd0;
  localparam logic [1:0] ZOOM_ALIAS1 = 2'd1;

  // Traffic modes, in the order the random phases use them.
  localparam int TRAFFIC_NONE  = 0;
  localparam int TRAFFIC_IDLE  = 1;
  localparam int TRAFFIC_STALL = 2;
  localparam int TRAFFIC_BOTH  = 3;

  localparam int          NUM_PHASES   = 8;
  localparam int          PHASE_PIXELS = 17;
  // A pixel that completes no block still keeps the block busy for its line
  // store read after the last output pixel has left, so the testbench settles
  // before touching the register or ending the run.
  localparam int          SETTLE       = 12;
  localparam int unsigned CYCLE_LIMIT  = 500_000;

  localparam logic [PIX_W-1:0] DIRECTED_PIXELS [24] = '{
    8'd0,   8'd255, 8'd255, 8'd0,   8'd0,   8'd255, 8'd128, 8'd1,
    8'd254, 8'd0,   8'd255, 8'd0,   8'd170, 8'd85,  8'd0,   8'd255,
    8'd255, 8'd0,   8'd0,   8'd255, 8'd255, 8'd0,   8'd127, 8'd255
  };

  // The zoom plan pairs every traffic mode with factor 3 and with factor 2
  // written one of three ways.
  localparam logic [1:0] ZOOM_PLAN [NUM_PHASES] = '{
    ZOOM_X3, ZOOM_ALIAS0, ZOOM_X3, ZOOM_X2, ZOOM_X3, ZOOM_ALIAS1, ZOOM_X3, ZOOM_X2
  };

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_we      = 1'b0;
  logic [1:0]           cfg_wdata   = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     pixel_value = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [COORD_W-1:0]   out_row;
  logic [COORD_W-1:0]   out_col;
  logic [PIX_W-1:0]     out_value;
  logic                 run_last;

  logic                 run_done    = 1'b0;
  int                   pend_count;
  int                   fail_count;
  int                   idle_pct    = 0;
  int                   stall_pct   = 0;
  int unsigned          cycle_count = 0;

  bilinear_integer_upscaler u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_value (pixel_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_value   (out_value),
    .run_last    (run_last)
  );

  upscale_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_value (pixel_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_value   (out_value),
    .run_last    (run_last),
    .run_done    (run_done),
    .pend_count  (pend_count),
    .fail_count  (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver draws a fresh stall decision every cycle from the current
  // traffic mode.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99, 0) < stall_pct);
    end
  end

  // Watchdog: a correct run finishes far below this count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offers one pixel, after a random number of idle cycles, and returns at
  // the edge that accepts it. Valid stays high on return so that the next
  // pixel can follow back to back.
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Waits until every predicted output pixel has arrived and the block has
  // had time to finish any pixel that produced nothing. The first edge lets
  // the checker account for a pixel accepted at the edge just passed.
  task automatic wait_idle();
    @(posedge clk);
    while (pend_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_zoom(input logic [1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_traffic(input int mode);
    case (mode)
      TRAFFIC_IDLE: begin
        idle_pct  = 69;
        stall_pct <= 0;
      end
      TRAFFIC_STALL: begin
        idle_pct  = 0;
        stall_pct <= 69;
      end
      TRAFFIC_BOTH: begin
        idle_pct  = 15;
        stall_pct <= 15;
      end
      default: begin
        idle_pct  = 0;
        stall_pct <= 0;
      end
    endcase
  endtask

  // Mostly full-range random pixels, with extra weight on black and white so
  // that the largest rising and falling steps show up often.
  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(255, 0));
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed start of an image at the reset zoom of 2: alternating black
    // and white in the first row and a half, with a few mid and near-extreme
    // values, so that the first blocks interpolate the steepest slopes.
    set_traffic(TRAFFIC_NONE);
    foreach (DIRECTED_PIXELS[k]) send_pixel(DIRECTED_PIXELS[k]);
    in_valid <= 1'b0;
    wait_idle();

    // Random phases, two per traffic mode. Pixel positions carry on across
    // phases, so the zoom is also changed in the middle of an image, as the
    // block allows.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_zoom(ZOOM_PLAN[ph]);
      set_traffic(ph / 2);
      for (int k = 0; k < PHASE_PIXELS; k++) send_pixel(random_pixel());
      in_valid <= 1'b0;
      set_traffic(TRAFFIC_NONE);
      wait_idle();
    end

    // Report anything still outstanding, then give the verdict.
    run_done <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
